@@ src/sst_pkg.sv @@
// Shared types and constants for the speech segment tracker.
// Holds register indexes, reset values, the window class code and the queue entry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_THRESHOLD     = 3'd0;
    localparam logic [2:0] REG_HYST_MARGIN   = 3'd1;
    localparam logic [2:0] REG_WINDOW        = 3'd2;
    localparam logic [2:0] REG_MIN_SILENCE   = 3'd3;
    localparam logic [2:0] REG_MIN_SPEECH    = 3'd4;
    localparam logic [2:0] REG_MAX_SPEECH    = 3'd5;
    localparam logic [2:0] REG_LONG_SILENCE  = 3'd6;

    // Reset values of the registers
    localparam logic [15:0] RST_THRESHOLD    = 16'd32768;
    localparam logic [15:0] RST_HYST_MARGIN  = 16'd9830;
    localparam logic [15:0] RST_WINDOW       = 16'd1024;
    localparam logic [31:0] RST_MIN_SILENCE  = 32'd0;
    localparam logic [31:0] RST_MIN_SPEECH   = 32'd1024;
    localparam logic [31:0] RST_MAX_SPEECH   = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_LONG_SILENCE = 32'd1568;

    // Result word width, padded to whole bytes
    localparam int unsigned RESULT_BITS = 66;
    localparam int unsigned TDATA_OUT_W = ((RESULT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [15:0] threshold;
        logic [15:0] hyst_margin;
        logic [15:0] window_samples;
        logic [31:0] min_silence;
        logic [31:0] min_speech;
        logic [31:0] max_speech;
        logic [31:0] long_silence;
    } cfg_t;

    // Window class decided by the front end
    typedef enum logic [1:0] {
        CLASS_MIDDLE  = 2'd0,
        CLASS_SPEECH  = 2'd1,
        CLASS_SILENCE = 2'd2
    } win_class_t;

    // One queued window
    typedef struct packed {
        win_class_t  wclass;
        logic [31:0] position;   // sample position after this window
        logic [31:0] win_start;  // sample position at window start
    } q_item_t;

endpackage

`default_nettype wire

@@ src/sst_queue.sv @@
// Two-entry queue between the front end and the segment engine.
// Depends on sst_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module sst_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire sst_pkg::q_item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output sst_pkg::q_item_t      pop_item,
    output logic                  not_empty
);
    import sst_pkg::*;

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ src/sst_front.sv @@
// Front end: accepts probability requests, tracks sample position and classifies windows.
// Depends on sst_pkg; feeds sst_queue.
`timescale 1ns / 1ps
`default_nettype none

module sst_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sst_pkg::cfg_t    cfg,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,   // [15:0] window probability
    output logic                  push,
    output sst_pkg::q_item_t      push_item,
    input  wire logic             q_full
);
    import sst_pkg::*;

    logic [31:0] position_reg, position_next;
    logic [16:0] prob_plus_margin;
    logic        is_speech, is_silence;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Position advances by one window per accepted request
    assign position_next = position_reg + {16'd0, cfg.window_samples};

    // Hysteresis band: silence when prob < threshold - margin, done without sign
    assign prob_plus_margin = {1'b0, s_tdata} + {1'b0, cfg.hyst_margin};
    assign is_speech        = (s_tdata >= cfg.threshold);
    assign is_silence       = (prob_plus_margin < {1'b0, cfg.threshold});

    always_comb begin
        push_item.position  = position_next;
        push_item.win_start = position_reg;
        if (is_speech) begin
            push_item.wclass = CLASS_SPEECH;
        end else if (is_silence) begin
            push_item.wclass = CLASS_SILENCE;
        end else begin
            push_item.wclass = CLASS_MIDDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= 32'd0;
        end else if (push) begin
            position_reg <= position_next;
        end
    end

endmodule

`default_nettype wire

@@ src/sst_back.sv @@
// Segment engine: holds the segment state and produces one result per window.
// Depends on sst_pkg; drains sst_queue into a registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module sst_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire sst_pkg::cfg_t                   cfg,
    input  wire sst_pkg::q_item_t                item,
    input  wire logic                            item_avail,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] segment_valid, [32:1] segment_start, [64:33] segment_end, [65] in_speech
    output logic [sst_pkg::TDATA_OUT_W-1:0]      m_tdata
);
    import sst_pkg::*;

    logic        speaking_reg, speaking_next;
    logic [31:0] open_start_reg, open_start_next;
    logic [31:0] silence_start_reg, silence_start_next;
    logic [31:0] split_end_reg, split_end_next;
    logic [31:0] resume_start_reg, resume_start_next;

    logic        m_tvalid_reg;
    logic [TDATA_OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic        seg_valid;
    logic [31:0] seg_start, seg_end;
    logic [31:0] seg_len, sil_start_eff, quiet, pre_len;
    logic        too_long;

    // Result stage frees when empty or being taken
    assign pop      = item_avail && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Lengths measured at the end of this window, all modulo 2^32
    assign seg_len       = item.position - open_start_reg;
    assign too_long      = speaking_reg && (seg_len > cfg.max_speech);
    assign sil_start_eff = (silence_start_reg == 32'd0) ? item.position : silence_start_reg;
    assign quiet         = item.position - sil_start_eff;
    assign pre_len       = sil_start_eff - open_start_reg;

    // Next segment state for the window at the queue head
    always_comb begin
        speaking_next      = speaking_reg;
        open_start_next    = open_start_reg;
        silence_start_next = silence_start_reg;
        split_end_next     = split_end_reg;
        resume_start_next  = resume_start_reg;
        seg_valid          = 1'b0;
        seg_start          = 32'd0;
        seg_end            = 32'd0;

        if (item.wclass == CLASS_SPEECH) begin
            // speech cancels pending silence, opens a segment if closed
            if (silence_start_reg != 32'd0) begin
                silence_start_next = 32'd0;
                if (resume_start_reg < split_end_reg) begin
                    resume_start_next = item.win_start;
                end
            end
            if (!speaking_reg) begin
                speaking_next   = 1'b1;
                open_start_next = item.win_start;
            end
        end else if (too_long) begin
            // overlong segment: split at last long silence, else cut here
            seg_valid = 1'b1;
            seg_start = open_start_reg;
            if (split_end_reg != 32'd0) begin
                seg_end = split_end_reg;
                if (resume_start_reg < split_end_reg) begin
                    speaking_next   = 1'b0;
                    open_start_next = 32'd0;
                end else begin
                    open_start_next = resume_start_reg;
                end
            end else begin
                seg_end         = item.position;
                speaking_next   = 1'b0;
                open_start_next = 32'd0;
            end
            split_end_next     = 32'd0;
            resume_start_next  = 32'd0;
            silence_start_next = 32'd0;
        end else if (item.wclass == CLASS_SILENCE && speaking_reg) begin
            silence_start_next = sil_start_eff;
            if (quiet > cfg.long_silence) begin
                split_end_next = sil_start_eff;
            end
            if (quiet >= cfg.min_silence && pre_len > cfg.min_speech) begin
                seg_valid          = 1'b1;
                seg_start          = open_start_reg;
                seg_end            = sil_start_eff;
                open_start_next    = 32'd0;
                split_end_next     = 32'd0;
                resume_start_next  = 32'd0;
                silence_start_next = 32'd0;
                speaking_next      = 1'b0;
            end
        end

        m_tdata_next = {{(TDATA_OUT_W - RESULT_BITS){1'b0}},
                        speaking_next, seg_end, seg_start, seg_valid};
    end

    // Segment state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speaking_reg      <= 1'b0;
            open_start_reg    <= 32'd0;
            silence_start_reg <= 32'd0;
            split_end_reg     <= 32'd0;
            resume_start_reg  <= 32'd0;
        end else if (pop) begin
            speaking_reg      <= speaking_next;
            open_start_reg    <= open_start_next;
            silence_start_reg <= silence_start_next;
            split_end_reg     <= split_end_next;
            resume_start_reg  <= resume_start_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

@@ src/speech_segment_tracker.sv @@
// Speech segment tracker: one result per speech probability request.
// An accepted request passes through the queue, then the result register, which drives the result.
// One request accepted and one queue entry retired per cycle unless the output stalls.
// A two-entry queue and a result register let input and output stall independently.
// Reset (aresetn low, synchronous) clears segment state, position, queue and registers
// to their default values; configuration writes are always accepted.
// Depends on sst_pkg, sst_front, sst_queue and sst_back.
`timescale 1ns / 1ps
`default_nettype none

module speech_segment_tracker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration write channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [31:0]                 cfg_data,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [15:0]                 s_tdata,   // [15:0] window probability
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [0] segment_valid, [32:1] segment_start, [64:33] segment_end, [65] in_speech
    output logic [sst_pkg::TDATA_OUT_W-1:0]  m_tdata
);
    import sst_pkg::*;

    cfg_t    cfg_reg;
    q_item_t push_item, pop_item;
    logic    push, q_full, pop, q_not_empty;

    assign cfg_ready = 1'b1;

    // Configuration registers, indexes beyond the list ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold      <= RST_THRESHOLD;
            cfg_reg.hyst_margin    <= RST_HYST_MARGIN;
            cfg_reg.window_samples <= RST_WINDOW;
            cfg_reg.min_silence    <= RST_MIN_SILENCE;
            cfg_reg.min_speech     <= RST_MIN_SPEECH;
            cfg_reg.max_speech     <= RST_MAX_SPEECH;
            cfg_reg.long_silence   <= RST_LONG_SILENCE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD:    cfg_reg.threshold      <= cfg_data[15:0];
                REG_HYST_MARGIN:  cfg_reg.hyst_margin    <= cfg_data[15:0];
                REG_WINDOW:       cfg_reg.window_samples <= cfg_data[15:0];
                REG_MIN_SILENCE:  cfg_reg.min_silence    <= cfg_data;
                REG_MIN_SPEECH:   cfg_reg.min_speech     <= cfg_data;
                REG_MAX_SPEECH:   cfg_reg.max_speech     <= cfg_data;
                REG_LONG_SILENCE: cfg_reg.long_silence   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    sst_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    sst_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (q_not_empty)
    );

    sst_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item       (pop_item),
        .item_avail (q_not_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_speech_segment_tracker.sv @@
// Self-checking testbench for speech_segment_tracker: drives probability requests and
// register writes, predicts every result in a scoreboard class and compares field by field.
// Depends on sst_pkg and the speech_segment_tracker RTL.
`timescale 1ns / 1ps

module tb_speech_segment_tracker;

    import sst_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 500000;
    localparam int unsigned ITEMS_PER_PHASE = 175;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam logic [2:0]  REG_SPARE       = 3'd7;   // outside the register map

    // Result fields as they sit in m_tdata, lowest bit last
    typedef struct packed {
        logic        in_speech;
        logic [31:0] seg_end;
        logic [31:0] seg_start;
        logic        closed;
    } window_result_t;

    typedef enum int { PK_SPEECH, PK_QUIET, PK_MIDDLE, PK_NOISE } prob_kind_t;
    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    // Tracks segments the way the block should and holds the results still owed
    class segment_scoreboard;
        cfg_t             regs;
        bit               speaking;
        bit [31:0]        position;
        bit [31:0]        open_start;
        bit [31:0]        silence_start;   // zero: no silence pending
        bit [31:0]        split_end;       // zero: no split point
        bit [31:0]        resume_start;
        window_result_t   window_results_q[$];
        int unsigned      mismatches;

        function new();
            regs = '{threshold: RST_THRESHOLD, hyst_margin: RST_HYST_MARGIN,
                     window_samples: RST_WINDOW, min_silence: RST_MIN_SILENCE,
                     min_speech: RST_MIN_SPEECH, max_speech: RST_MAX_SPEECH,
                     long_silence: RST_LONG_SILENCE};
            speaking      = 1'b0;
            position      = '0;
            open_start    = '0;
            silence_start = '0;
            split_end     = '0;
            resume_start  = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_THRESHOLD:    regs.threshold      = val[15:0];
                REG_HYST_MARGIN:  regs.hyst_margin    = val[15:0];
                REG_WINDOW:       regs.window_samples = val[15:0];
                REG_MIN_SILENCE:  regs.min_silence    = val;
                REG_MIN_SPEECH:   regs.min_speech     = val;
                REG_MAX_SPEECH:   regs.max_speech     = val;
                REG_LONG_SILENCE: regs.long_silence   = val;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return window_results_q.size();
        endfunction

        // Advance by one window and queue the result it should give
        function void note_window(logic [15:0] prob);
            window_result_t r;
            bit [31:0]      win_start;
            bit [31:0]      span;
            bit [31:0]      quiet;
            int             low_level;

            r = '0;
            low_level = int'(regs.threshold) - int'(regs.hyst_margin);
            position  = position + regs.window_samples;
            win_start = position - regs.window_samples;
            span      = position - open_start;

            if (prob >= regs.threshold) begin
                // speech cancels a pending silence; note where speech resumed
                if (silence_start != 0) begin
                    silence_start = '0;
                    if (resume_start < split_end)
                        resume_start = win_start;
                end
                if (!speaking) begin
                    speaking   = 1'b1;
                    open_start = win_start;
                end
            end else if (speaking && span > regs.max_speech) begin
                // over length: split at the last long silence, or cut here
                r.closed    = 1'b1;
                r.seg_start = open_start;
                if (split_end > 0) begin
                    r.seg_end = split_end;
                    if (resume_start < split_end) begin
                        speaking   = 1'b0;
                        open_start = '0;
                    end else begin
                        open_start = resume_start;
                    end
                end else begin
                    r.seg_end  = position;
                    speaking   = 1'b0;
                    open_start = '0;
                end
                split_end     = '0;
                resume_start  = '0;
                silence_start = '0;
            end else if (int'(prob) < low_level && speaking) begin
                if (silence_start == 0)
                    silence_start = position;
                quiet = position - silence_start;
                if (quiet > regs.long_silence)
                    split_end = silence_start;
                if (quiet >= regs.min_silence &&
                        (silence_start - open_start) > regs.min_speech) begin
                    r.closed      = 1'b1;
                    r.seg_start   = open_start;
                    r.seg_end     = silence_start;
                    open_start    = '0;
                    split_end     = '0;
                    resume_start  = '0;
                    silence_start = '0;
                    speaking      = 1'b0;
                end
            end

            r.in_speech = speaking;
            window_results_q.insert(window_results_q.size(), r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v) begin
                $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_window_result(logic [TDATA_OUT_W-1:0] data);
            window_result_t got;
            window_result_t exp_r;

            got = data[$bits(window_result_t)-1:0];
            if (window_results_q.size() == 0) begin
                $display("%0t: no result expected, got %h", $time, got);
                mismatches++;
                return;
            end
            exp_r = window_results_q.pop_front();
            compare_field("segment_valid", exp_r.closed, got.closed);
            compare_field("segment_start", exp_r.seg_start, got.seg_start);
            compare_field("segment_end", exp_r.seg_end, got.seg_end);
            compare_field("in_speech", exp_r.in_speech, got.in_speech);
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index = '0;
    logic [31:0]            cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;     // [15:0] window probability
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [0] segment_valid, [32:1] segment_start, [64:33] segment_end, [65] in_speech
    logic [TDATA_OUT_W-1:0] m_tdata;

    segment_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_trigger   = 0;
    int unsigned cycle_count    = 0;

    bit [15:0] opening_probs [8] = '{16'd0, 16'd65535, 16'd32768, 16'd32767,
                                     16'd22938, 16'd22937, 16'd22937, 16'd0};
    prob_kind_t split_kinds [18] = '{PK_SPEECH, PK_SPEECH, PK_SPEECH,
                                     PK_QUIET, PK_QUIET, PK_QUIET,
                                     PK_SPEECH, PK_SPEECH,
                                     PK_MIDDLE, PK_MIDDLE, PK_MIDDLE, PK_MIDDLE, PK_MIDDLE,
                                     PK_MIDDLE, PK_MIDDLE, PK_MIDDLE, PK_MIDDLE, PK_MIDDLE};

    speech_segment_tracker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Handshake monitor: register writes, accepted requests, returned results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_window(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_window_result(m_tdata);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= WATCHDOG_CYCLES) begin
            $display("speech_segment_tracker: mismatch");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_trigger != hold_seen) begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one request, idling first at the current rate
    task automatic push_prob(input logic [15:0] prob);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= prob;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait for every owed result, after first letting the last
    // accepted request be noted
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write every register; junk in the upper half of the 16-bit ones must be dropped
    task automatic program_settings(input cfg_t c);
        write_reg(REG_THRESHOLD, {16'($urandom), c.threshold});
        write_reg(REG_HYST_MARGIN, {16'($urandom), c.hyst_margin});
        write_reg(REG_WINDOW, {16'($urandom), c.window_samples});
        write_reg(REG_MIN_SILENCE, c.min_silence);
        write_reg(REG_MIN_SPEECH, c.min_speech);
        write_reg(REG_MAX_SPEECH, c.max_speech);
        write_reg(REG_LONG_SILENCE, c.long_silence);
        write_reg(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic void set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 67; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default:       begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endfunction

    // Probability in the wanted band of the current settings
    function automatic logic [15:0] pick_prob(prob_kind_t kind);
        int thr;
        int low;
        thr = int'(sb.regs.threshold);
        low = thr - int'(sb.regs.hyst_margin);
        case (kind)
            PK_SPEECH:
                return ($urandom_range(3) == 0) ? 16'(thr) : 16'($urandom_range(65535, thr));
            PK_QUIET:
                return (low > 0) ? 16'($urandom_range(low - 1, 0)) : 16'($urandom);
            PK_MIDDLE: begin
                if (low < 0)
                    low = 0;
                if (thr <= low)
                    return 16'($urandom);
                return ($urandom_range(3) == 0) ? 16'(low) : 16'($urandom_range(thr - 1, low));
            end
            default:
                return 16'($urandom);
        endcase
    endfunction

    // Lengths are mostly a few windows so that splits and closes happen often
    function automatic cfg_t random_settings();
        cfg_t        c;
        int unsigned r;
        int unsigned unit;

        r = $urandom_range(99);
        c.window_samples = (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF : 16'($urandom_range(2048, 1));
        unit = (c.window_samples == 0) ? $urandom_range(2048, 1) : c.window_samples;

        r = $urandom_range(99);
        c.threshold = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : 16'($urandom_range(60000, 8000));
        r = $urandom_range(99);
        c.hyst_margin = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : 16'($urandom_range(20000, 0));

        r = $urandom_range(99);
        c.min_silence = (r < 10) ? 32'd0 : (r < 15) ? '1 : 32'(unit * $urandom_range(4, 0));
        r = $urandom_range(99);
        c.min_speech = (r < 10) ? 32'd0 : (r < 15) ? '1 : 32'(unit * $urandom_range(6, 0));
        r = $urandom_range(99);
        c.max_speech = (r < 25) ? '1 : (r < 30) ? 32'd0 : 32'(unit * $urandom_range(25, 3));
        r = $urandom_range(99);
        c.long_silence = (r < 10) ? 32'd0 : (r < 15) ? '1 : 32'(unit * $urandom_range(4, 0));
        return c;
    endfunction

    // Runs of speech, silence, middle band and noise
    task automatic random_items(input int unsigned count);
        int unsigned left;
        int unsigned r;
        int unsigned run;
        prob_kind_t  kind;
        left = count;
        while (left > 0) begin
            r    = $urandom_range(99);
            kind = (r < 40) ? PK_SPEECH : (r < 75) ? PK_QUIET : (r < 90) ? PK_MIDDLE : PK_NOISE;
            run  = $urandom_range(10, 1);
            while (run > 0 && left > 0) begin
                push_prob(pick_prob(kind));
                run--;
                left--;
            end
        end
    endtask

    // Stimulus
    initial begin
        cfg_t c;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // band edges and both extremes under the reset settings
        foreach (opening_probs[i])
            push_prob(opening_probs[i]);
        drain_results();

        // long segment split at an earlier long silence, then carried on
        c = '{threshold: 16'd32768, hyst_margin: 16'd9830, window_samples: 16'd100,
              min_silence: 32'd1000, min_speech: 32'd0, max_speech: 32'd1500,
              long_silence: 32'd150};
        program_settings(c);
        foreach (split_kinds[i])
            push_prob(pick_prob(split_kinds[i]));
        drain_results();

        for (int phase = 0; phase < 10; phase++) begin
            set_idle(idle_mode_t'(phase % 4));
            if (phase == 0)
                c = '{threshold: 16'hFFFF, hyst_margin: 16'd0, window_samples: 16'hFFFF,
                      min_silence: '1, min_speech: '1, max_speech: 32'd0, long_silence: 32'd0};
            else if (phase == 5)
                c = '{threshold: 16'd0, hyst_margin: 16'hFFFF, window_samples: 16'd0,
                      min_silence: 32'd0, min_speech: 32'd0, max_speech: 32'd0,
                      long_silence: 32'd0};
            else
                c = random_settings();
            program_settings(c);

            // receiver holds off while requests keep coming, so the input backs up
            if (phase == 2) begin
                send_idle_pct = 0;
                hold_trigger++;
                random_items(40);
                set_idle(idle_mode_t'(phase % 4));
            end
            random_items(ITEMS_PER_PHASE);
            drain_results();
        end

        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("speech_segment_tracker: match");
        else
            $display("speech_segment_tracker: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
src/sst_pkg.sv
src/sst_queue.sv
src/sst_front.sv
src/sst_back.sv
src/speech_segment_tracker.sv
tb/sv/tb_speech_segment_tracker.sv
